// File: rtl/core/hmi_reply_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// hmi_reply_frame_parser assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef HMI_REPLY_FRAME_PARSER_MACROS_SVH
`define HMI_REPLY_FRAME_PARSER_MACROS_SVH

// property must hold at every edge outside reset
`define HRFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be true outside reset
`define HRFP_ASSERT_NEVER(label, cond, msg) \
  `HRFP_ASSERT(label, !(cond), msg)

`endif

// File: rtl/core/hrfp_pkg.sv
// ----------------------------------------------------------------------------
// hrfp_pkg
// Types and constants shared by the reply frame parser modules.
// ----------------------------------------------------------------------------
package hrfp_pkg;

  localparam logic [7:0] TermByte  = 8'hFF;
  localparam logic [7:0] HdrString = 8'h70;
  localparam logic [7:0] HdrNumber = 8'h71;

  localparam int NumberFrameLen = 8;
  localparam int FrameOverhead  = 4;
  localparam int NumberBytes    = 4;

  // body length field, sized for the largest supported buffer depth
  localparam int LenW = 8;

  localparam int JobQDepth = 2;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              bank;
    logic [LenW-1:0]   len;
    logic [31:0]       number;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

// File: rtl/core/hrfp_ram.sv
// ----------------------------------------------------------------------------
// hrfp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hrfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/hrfp_front.sv
// ----------------------------------------------------------------------------
// hrfp_front
// Stores received bytes, spots the 0xFF 0xFF 0xFF terminator and queues a
// job per complete string frame or number frame of the expected length. Two
// buffer banks let a new frame fill while the previous string body drains.
// ----------------------------------------------------------------------------
`include "hmi_reply_frame_parser_macros.svh"

module hrfp_front #(
  parameter int BufferDepth = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [7:0]                     rx_byte_i,
  output logic                           full_o,
  output logic                           we_o,
  output logic [$clog2(BufferDepth):0]   waddr_o,
  output logic [7:0]                     wdata_o,
  output logic                           job_push_o,
  output hrfp_pkg::job_t                 job_o,
  input  logic                           job_full_i,
  input  hrfp_pkg::release_t             rel_i
);

  localparam int AW = $clog2(BufferDepth);

  logic [AW-1:0] cnt_q, cnt_d;
  logic [1:0]    run_q, run_d;
  logic [7:0]    hdr_q, hdr_d;
  logic [31:0]   num_q, num_d;
  logic          bank_q, bank_d;
  logic [1:0]    busy_q, busy_d;
  logic          accept;
  logic          is_ff;
  logic          term;

  assign full_o  = job_full_i || busy_q[bank_q];
  assign accept  = push_i && !full_o;
  assign is_ff   = (rx_byte_i == hrfp_pkg::TermByte);
  assign term    = is_ff && (run_q == 2'd2);

  assign we_o    = accept;
  assign waddr_o = {bank_q, cnt_q};
  assign wdata_o = rx_byte_i;

  always_comb begin
    cnt_d      = cnt_q;
    run_d      = run_q;
    hdr_d      = hdr_q;
    num_d      = num_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    job_push_o = 1'b0;
    job_o      = '0;
    job_o.kind = hrfp_pkg::KIND_CHAR;
    job_o.bank = bank_q;
    job_o.len  = hrfp_pkg::LenW'(cnt_q - AW'(hrfp_pkg::FrameOverhead - 1));
    job_o.number = num_q;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      if (cnt_q == '0) begin
        hdr_d = rx_byte_i;
      end
      for (int k = 1; k <= hrfp_pkg::NumberBytes; k++) begin
        if (cnt_q == AW'(k)) begin
          num_d[8*(k-1) +: 8] = rx_byte_i;
        end
      end
      if (is_ff) begin
        run_d = (run_q == 2'd2) ? 2'd2 : run_q + 2'd1;
      end else begin
        run_d = 2'd0;
      end

      priority if (term) begin
        cnt_d = '0;
        run_d = 2'd0;
        if (hdr_q == hrfp_pkg::HdrString) begin
          job_push_o = 1'b1;
          if (cnt_q == AW'(hrfp_pkg::FrameOverhead - 1)) begin
            job_o.kind = hrfp_pkg::KIND_EMPTY;
          end else begin
            job_o.kind     = hrfp_pkg::KIND_CHAR;
            bank_d         = ~bank_q;
            busy_d[bank_q] = 1'b1;
          end
        end else if (hdr_q == hrfp_pkg::HdrNumber &&
                     cnt_q == AW'(hrfp_pkg::NumberFrameLen - 1)) begin
          job_push_o = 1'b1;
          job_o.kind = hrfp_pkg::KIND_NUMBER;
        end
      end else if (cnt_q == AW'(BufferDepth - 1)) begin
        cnt_d = '0;
        run_d = 2'd0;
      end else begin
        cnt_d = cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 2'd0;
      bank_q <= 1'b0;
      busy_q <= 2'b00;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    num_q <= num_d;
  end

  `HRFP_ASSERT_NEVER(a_push_into_full_queue, job_push_o && job_full_i,
                     "job pushed into a full queue")
  `HRFP_ASSERT_NEVER(a_release_idle_bank, rel_i.valid && !busy_q[rel_i.bank],
                     "release of a bank with no pending job")
  `HRFP_ASSERT(a_bank_flip_marks_busy, (bank_q != $past(bank_q)) |-> busy_q[$past(bank_q)],
               "bank switched without marking the old bank busy")

endmodule

// File: rtl/core/hrfp_job_fifo.sv
// ----------------------------------------------------------------------------
// hrfp_job_fifo
// Short queue of frame jobs between the front and back parts.
// ----------------------------------------------------------------------------
module hrfp_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hrfp_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output hrfp_pkg::job_t data_o,
  output logic           empty_o
);

  localparam int PW = $clog2(hrfp_pkg::JobQDepth);
  localparam int CW = $clog2(hrfp_pkg::JobQDepth + 1);

  hrfp_pkg::job_t entry_q [hrfp_pkg::JobQDepth];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(hrfp_pkg::JobQDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(hrfp_pkg::JobQDepth - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(hrfp_pkg::JobQDepth - 1)) ? '0 : rptr_q + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/core/hrfp_back.sv
// ----------------------------------------------------------------------------
// hrfp_back
// Runs queued frame jobs: walks string bodies out of the buffer one byte
// at a time and presents every result in an output register.
// ----------------------------------------------------------------------------
`include "hmi_reply_frame_parser_macros.svh"

module hrfp_back #(
  parameter int BufferDepth = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hrfp_pkg::job_t               job_i,
  input  logic                         job_empty_i,
  output logic                         job_pop_o,
  output logic                         re_o,
  output logic [$clog2(BufferDepth):0] raddr_o,
  input  logic [7:0]                   rdata_i,
  output hrfp_pkg::release_t           rel_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output hrfp_pkg::kind_e              kind_o,
  output logic [7:0]                   text_char_o,
  output logic signed [31:0]           number_value_o,
  output logic                         last_o
);

  localparam int AW = $clog2(BufferDepth);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_LOAD   = 4'b0100,
    S_SINGLE = 4'b1000
  } back_state_e;

  back_state_e     state_q, state_d;
  hrfp_pkg::job_t  job_q, job_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  hrfp_pkg::kind_e out_kind_q, out_kind_d;
  logic [7:0]      out_char_q, out_char_d;
  logic [31:0]     out_num_q, out_num_d;
  logic            out_last_q, out_last_d;
  logic            out_free;
  logic            body_end;

  assign out_free = !out_valid_q || pop_i;
  assign body_end = (idx_q == AW'(job_q.len));
  assign raddr_o  = {job_q.bank, idx_q};

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !pop_i;
    out_kind_d  = out_kind_q;
    out_char_d  = out_char_q;
    out_num_d   = out_num_q;
    out_last_d  = out_last_q;
    job_pop_o   = 1'b0;
    re_o        = 1'b0;
    rel_o       = '0;
    rel_o.bank  = job_q.bank;

    unique case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          idx_d     = AW'(1);
          state_d   = (job_i.kind == hrfp_pkg::KIND_CHAR) ? S_READ : S_SINGLE;
        end
      end
      S_READ: begin
        re_o    = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = hrfp_pkg::KIND_CHAR;
          out_char_d  = rdata_i;
          out_num_d   = '0;
          out_last_d  = body_end;
          if (body_end) begin
            rel_o.valid = 1'b1;
            state_d     = S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_READ;
          end
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = job_q.kind;
          out_char_d  = '0;
          out_num_d   = (job_q.kind == hrfp_pkg::KIND_NUMBER) ? job_q.number : '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    idx_q      <= idx_d;
    out_kind_q <= out_kind_d;
    out_char_q <= out_char_d;
    out_num_q  <= out_num_d;
    out_last_q <= out_last_d;
  end

  assign empty_o        = !out_valid_q;
  assign kind_o         = out_kind_q;
  assign text_char_o    = out_char_q;
  assign number_value_o = signed'(out_num_q);
  assign last_o         = out_last_q;

  `HRFP_ASSERT(a_read_then_load, re_o |=> (state_q == S_LOAD),
               "buffer read not followed by load")
  `HRFP_ASSERT(a_single_is_last, (out_valid_q && out_kind_q != hrfp_pkg::KIND_CHAR) |-> out_last_q,
               "number or empty result not marked last")
  `HRFP_ASSERT_NEVER(a_pop_while_busy, job_pop_o && (state_q != S_IDLE),
                     "job taken while another is running")

endmodule

// File: rtl/core/hmi_reply_frame_parser.sv
// ----------------------------------------------------------------------------
// hmi_reply_frame_parser
// Display reply link frame parser: string and number frames ended by
// 0xFF 0xFF 0xFF.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive rx_byte_i with push_i; a byte is taken when push_i
//   is high and full_o is low. full_o rises only when the job queue is full
//   or both buffer banks hold string bodies still waiting to drain.
//   Result channel: a result is on kind_o, text_char_o, number_value_o and
//   last_o while empty_o is low and is taken when pop_i is high.
//   String characters leave by one buffer read followed by one output load;
//   the load waits while the output register still holds an untaken result.
//   A stalled receiver holds the output register; the front keeps taking
//   bytes into the other bank until the queue or banks run out.
//   Reset clears the fill count, bank state, job queue and output register;
//   buffer contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module hmi_reply_frame_parser #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [7:0]         rx_byte_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         text_char_o,
  output logic signed [31:0] number_value_o,
  output logic               last_o
);

  localparam int RamAW = $clog2(BUFFER_DEPTH) + 1;

  logic               we;
  logic [RamAW-1:0]   waddr;
  logic [7:0]         wdata;
  logic               re;
  logic [RamAW-1:0]   raddr;
  logic [7:0]         rdata;
  logic               job_push;
  logic               job_pop;
  logic               job_full;
  logic               job_empty;
  hrfp_pkg::job_t     job_in;
  hrfp_pkg::job_t     job_out;
  hrfp_pkg::release_t rel;
  hrfp_pkg::kind_e    kind;

  hrfp_front #(
    .BufferDepth(BUFFER_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full_o),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full),
    .rel_i      (rel)
  );

  hrfp_ram #(
    .Width(8),
    .Depth(2 * (2 ** (RamAW - 1)))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hrfp_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  hrfp_back #(
    .BufferDepth(BUFFER_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_out),
    .job_empty_i    (job_empty),
    .job_pop_o      (job_pop),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .rel_o          (rel),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .kind_o         (kind),
    .text_char_o    (text_char_o),
    .number_value_o (number_value_o),
    .last_o         (last_o)
  );

  assign kind_o = kind;

endmodule
